// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

  // Field and register widths.
  localparam int TICK_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int LONG_W     = 16;
  localparam int REPEAT_W   = 16;
  localparam int CFG_DATA_W = 16;

  // Register values after reset.
  localparam logic [COUNT_W-1:0]  DEBOUNCE_RESET = 8'd2;
  localparam logic [LONG_W-1:0]   LONG_RESET     = 16'd1000;
  localparam logic [REPEAT_W-1:0] REPEAT_RESET   = 16'd200;

  // Machine states, as reported in fsm_state.
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_PRESS_DEB = 3'd1,
    ST_PRESSED   = 3'd2,
    ST_LONG_ONCE = 3'd3,
    ST_LONG_REP  = 3'd4,
    ST_REL_DEB   = 3'd5,
    ST_RELEASED  = 3'd6
  } phase_t;

  // Event codes, as reported in event_code.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CLICK   = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_t;

  // Which long-press state was held before a release started.
  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_ONCE = 2'd1,
    HELD_REP  = 2'd2
  } held_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_REPEAT   = 2'd2,
    CFG_MODE     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  debounce_scans;
    logic [LONG_W-1:0]   long_press_ticks;
    logic [REPEAT_W-1:0] repeat_ticks;
    logic                repeat_mode;
  } cfg_t;

  typedef struct packed {
    logic              pin_level;
    logic [TICK_W-1:0] tick_now;
  } scan_t;

  typedef struct packed {
    event_t event_code;
    phase_t fsm_state;
  } result_t;

endpackage

// ===== hdl/bpc_if.sv =====
// Scan channel: one raw button sample with its timestamp per transaction.
interface bpc_scan_if;
  logic                      valid;
  logic                      ready;
  logic                      pin_level;
  logic [bpc_pkg::TICK_W-1:0] tick_now;

  modport source (output valid, output pin_level, output tick_now, input ready);
  modport sink   (input valid, input pin_level, input tick_now, output ready);
endinterface

// Result channel: one event and state report per transaction.
interface bpc_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [2:0] fsm_state;

  modport source (output valid, output event_code, output fsm_state, input ready);
  modport sink   (input valid, input event_code, input fsm_state, output ready);
endinterface

// ===== hdl/bpc_cfg_regs.sv =====
module bpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  bpc_pkg::cfg_index_t            cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bpc_pkg::cfg_t                  cfg
);
  import bpc_pkg::*;

  // Register file, loaded with defaults at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_scans   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_RESET;
      cfg.repeat_ticks     <= REPEAT_RESET;
      cfg.repeat_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg.debounce_scans   <= cfg_data[COUNT_W-1:0];
        CFG_LONG:     cfg.long_press_ticks <= cfg_data[LONG_W-1:0];
        CFG_REPEAT:   cfg.repeat_ticks     <= cfg_data[REPEAT_W-1:0];
        CFG_MODE:     cfg.repeat_mode      <= cfg_data[0];
        default:      cfg.repeat_mode      <= cfg.repeat_mode;
      endcase
    end
  end

endmodule

// ===== hdl/bpc_fsm.sv =====
module bpc_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  bpc_pkg::scan_t   scan,
  input  bpc_pkg::cfg_t    cfg,
  output bpc_pkg::result_t res
);
  import bpc_pkg::*;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] stable_count, stable_count_next;
  logic [TICK_W-1:0]  mark_time, mark_time_next;
  held_t              held_long, held_long_next;

  logic [TICK_W-1:0]  elapsed;
  logic [COUNT_W-1:0] count_inc;
  logic               count_ok;
  logic               long_hit;
  logic               repeat_hit;
  event_t             ev;

  // Shared arithmetic: time since the mark and the saturating stable count.
  assign elapsed    = scan.tick_now - mark_time;
  assign count_inc  = (stable_count == {COUNT_W{1'b1}}) ? stable_count
                                                        : stable_count + 1'b1;
  assign count_ok   = count_inc >= cfg.debounce_scans;
  assign long_hit   = elapsed >= {{(TICK_W-LONG_W){1'b0}}, cfg.long_press_ticks};
  assign repeat_hit = elapsed >= {{(TICK_W-REPEAT_W){1'b0}}, cfg.repeat_ticks};

  // State registers advance once per processed scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ST_IDLE;
      stable_count <= '0;
      mark_time    <= '0;
      held_long    <= HELD_NONE;
    end else if (step) begin
      phase        <= phase_next;
      stable_count <= stable_count_next;
      mark_time    <= mark_time_next;
      held_long    <= held_long_next;
    end
  end

  // Next state and event for the scan in the input register.
  always_comb begin
    phase_next        = phase;
    stable_count_next = stable_count;
    mark_time_next    = mark_time;
    held_long_next    = held_long;
    ev                = EV_NONE;
    unique case (phase)
      ST_PRESS_DEB: begin
        if (!scan.pin_level) begin
          stable_count_next = count_inc;
          if (count_ok) begin
            phase_next     = ST_PRESSED;
            mark_time_next = scan.tick_now;
            held_long_next = HELD_NONE;
          end
        end else begin
          phase_next = ST_IDLE;
        end
      end
      ST_PRESSED: begin
        if (scan.pin_level) begin
          phase_next        = ST_REL_DEB;
          stable_count_next = '0;
          ev                = EV_CLICK;
        end else if (long_hit) begin
          if (!cfg.repeat_mode) begin
            phase_next     = ST_LONG_ONCE;
            held_long_next = HELD_ONCE;
            ev             = EV_LONG;
          end else begin
            phase_next     = ST_LONG_REP;
            held_long_next = HELD_REP;
            mark_time_next = scan.tick_now;
            ev             = EV_REPEAT;
          end
        end
      end
      ST_LONG_ONCE: begin
        if (scan.pin_level) begin
          phase_next        = ST_REL_DEB;
          stable_count_next = '0;
        end
      end
      ST_LONG_REP: begin
        if (scan.pin_level) begin
          phase_next        = ST_REL_DEB;
          stable_count_next = '0;
        end else if (repeat_hit) begin
          mark_time_next = scan.tick_now;
          ev             = EV_REPEAT;
        end
      end
      ST_REL_DEB: begin
        if (scan.pin_level) begin
          stable_count_next = count_inc;
          if (count_ok) begin
            phase_next     = ST_RELEASED;
            held_long_next = HELD_NONE;
            ev             = EV_RELEASE;
          end
        end else begin
          // A bounce goes back to whichever pressed state was held.
          unique case (held_long)
            HELD_ONCE: phase_next = ST_LONG_ONCE;
            HELD_REP:  phase_next = ST_LONG_REP;
            default:   phase_next = ST_PRESSED;
          endcase
        end
      end
      default: begin
        // Idle and released both wait for the first low scan.
        phase_next = (phase == ST_RELEASED) ? ST_RELEASED : ST_IDLE;
        if (!scan.pin_level) begin
          phase_next        = ST_PRESS_DEB;
          stable_count_next = '0;
          held_long_next    = HELD_NONE;
        end
      end
    endcase
    res.event_code = ev;
    res.fsm_state  = phase_next;
  end

endmodule

// ===== hdl/button_press_classifier.sv =====
// Channel   Dir  Handshake          Payload
// scan      in   valid/ready        pin_level, tick_now
// report    out  valid/ready        event_code, fsm_state
// cfg       in   cfg_we only        cfg_index, cfg_data
//
// One scan per cycle is sustained while report is not stalled; each transaction yields one
// report after acceptance (input register, then result register).
// The state machine update between the two registers sets the rate.
// Reset (rst, synchronous) empties both registers and returns the machine
// to idle with default configuration.
// A stalled report holds the result register and the input register; scan
// stays ready as long as the input register is empty or can move forward.
module button_press_classifier (
  input  logic                           clk,
  input  logic                           rst,
  bpc_scan_if.sink                       scan,
  bpc_result_if.source                   report,
  input  logic                           cfg_we,
  input  bpc_pkg::cfg_index_t            cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bpc_pkg::*;

  cfg_t    cfg;
  scan_t   s1_scan;
  logic    s1_valid;
  result_t res;
  result_t out_res;
  logic    out_valid;
  logic    advance;
  logic    step;

  bpc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .scan (s1_scan),
    .cfg  (cfg),
    .res  (res)
  );

  // Pipeline flow control: the input register moves when the result
  // register is empty or being drained.
  assign advance    = !out_valid || report.ready;
  assign step       = s1_valid && advance;
  assign scan.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (scan.ready) begin
        s1_valid <= scan.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_scan.pin_level <= scan.pin_level;
      s1_scan.tick_now  <= scan.tick_now;
    end
    if (step) begin
      out_res <= res;
    end
  end

  assign report.valid      = out_valid;
  assign report.event_code = out_res.event_code;
  assign report.fsm_state  = out_res.fsm_state;

endmodule

// ===== hdl/bpc_checker.sv =====
module bpc_assertions (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_code,
  input logic [2:0] fsm_state
);
  import bpc_pkg::*;

  logic [2:0] last_state;

  // State of the most recently delivered report.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_state <= ST_IDLE;
    end else if (out_valid && out_ready) begin
      last_state <= fsm_state;
    end
  end

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("report valid after reset");

  // A stalled report holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(event_code) && $stable(fsm_state))
    else $error("stalled report changed");

  // Each event lands in the state it belongs to.
  a_event_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (event_code != EV_CLICK   || fsm_state == ST_REL_DEB) &&
      (event_code != EV_LONG    || fsm_state == ST_LONG_ONCE) &&
      (event_code != EV_REPEAT  || fsm_state == ST_LONG_REP) &&
      (event_code != EV_RELEASE || fsm_state == ST_RELEASED))
    else $error("event does not match reported state");

  // Click follows a pressed report; release follows a release-debounce report.
  a_event_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |->
      (event_code != EV_CLICK   || last_state == ST_PRESSED) &&
      (event_code != EV_RELEASE || last_state == ST_REL_DEB))
    else $error("event from wrong previous state");

endmodule

bind button_press_classifier bpc_assertions u_bpc_assertions (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (report.valid),
  .out_ready  (report.ready),
  .event_code (report.event_code),
  .fsm_state  (report.fsm_state)
);
